[rtl/mtlt_pkg.sv]
package mtlt_pkg;

  // Fixed field widths
  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned MotionW     = 32;
  localparam int unsigned MsW         = 16;
  localparam int unsigned LayerW      = 5;
  localparam int unsigned DeltaW      = 16;
  localparam int unsigned ReqW        = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  // Request codes
  localparam logic [ReqW-1:0] REQ_MOTION = 2'd0;
  localparam logic [ReqW-1:0] REQ_TICK   = 2'd1;
  localparam logic [ReqW-1:0] REQ_FORCE  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DELAY      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LAYER      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INACTIVITY = 3'd4;

  // Reset values of the configuration registers
  localparam logic [MsW-1:0]    THRESHOLD_RST  = 16'd128;
  localparam logic [MsW-1:0]    GAP_RST        = 16'd100;
  localparam logic [MsW-1:0]    DELAY_RST      = 16'd0;
  localparam logic [LayerW-1:0] LAYER_RST      = 5'd0;
  localparam logic [MsW-1:0]    INACTIVITY_RST = 16'd0;

  // Fallback windows when the movement gap is zero
  localparam logic [MsW-1:0] IDLE_DROP_MS     = 16'd8;
  localparam logic [MsW-1:0] BLOCK_RELEASE_MS = 16'd50;

  typedef struct packed {
    logic              layer_active;
    logic [LayerW-1:0] active_layer;
    logic              layer_on_pulse;
    logic              layer_off_pulse;
    logic [LayerW-1:0] off_layer;
    logic              reactivation_blocked;
  } result_t;

  function automatic logic [MotionW-1:0] sat_add(input logic [MotionW-1:0] a,
                                                 input logic [MotionW-1:0] b);
    logic [MotionW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = sum[MotionW] ? {MotionW{1'b1}} : sum[MotionW-1:0];
  endfunction

endpackage

[rtl/motion_threshold_layer_trigger.sv]
// A result item is registered when its input item is accepted, in the main slot or,
//   while that is stalled, in the skid slot. Throughput: one item per cycle while
//   the skid slot is empty; all state is updated by one pass of compare/add logic at
//   the input handshake; the two-entry buffer lets input go on through a stall.
// Reset: rst_ni clears all timing and layer state and loads the register defaults
//   (threshold 128, gap 100 ms, everything else zero); the result buffer empties.
module motion_threshold_layer_trigger #(
  parameter int unsigned TIME_BITS = mtlt_pkg::TimeBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mtlt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mtlt_pkg::CfgDataW-1:0]     cfg_data_i,
  // input item channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mtlt_pkg::ReqW-1:0]         req_type_i,
  input  logic signed [mtlt_pkg::DeltaW-1:0] move_delta_i,
  input  logic [mtlt_pkg::LayerW-1:0]       force_layer_i,
  // result item channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              layer_active_o,
  output logic [mtlt_pkg::LayerW-1:0]       active_layer_o,
  output logic                              layer_on_pulse_o,
  output logic                              layer_off_pulse_o,
  output logic [mtlt_pkg::LayerW-1:0]       off_layer_o,
  output logic                              reactivation_blocked_o
);

  localparam int unsigned MotionW = mtlt_pkg::MotionW;
  localparam int unsigned MsW     = mtlt_pkg::MsW;
  localparam int unsigned LayerW  = mtlt_pkg::LayerW;
  localparam int unsigned DeltaW  = mtlt_pkg::DeltaW;

  // Configuration registers
  logic [MsW-1:0]    thr_q, gap_q, delay_q, inact_q;
  logic [LayerW-1:0] target_q;

  // Trigger state; a time stamp of zero reads as "none"
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [MotionW-1:0]   pending_q, pending_d;
  logic [MotionW-1:0]   accum_q, accum_d;
  logic                 seen_q, seen_d;
  logic [TIME_BITS-1:0] seq_start_q, seq_start_d;
  logic [TIME_BITS-1:0] last_move_q, last_move_d;
  logic [TIME_BITS-1:0] block_move_q, block_move_d;
  logic                 block_q, block_d;
  logic                 active_q, active_d;
  logic [LayerW-1:0]    held_layer_q, held_layer_d;
  logic [MsW-1:0]       held_tmo_q, held_tmo_d;
  logic [TIME_BITS-1:0] last_act_q, last_act_d;

  // Result buffer: main slot plus skid slot
  mtlt_pkg::result_t out_q, skid_q, res;
  logic              out_valid_q, skid_valid_q;

  logic in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= mtlt_pkg::THRESHOLD_RST;
      gap_q    <= mtlt_pkg::GAP_RST;
      delay_q  <= mtlt_pkg::DELAY_RST;
      target_q <= mtlt_pkg::LAYER_RST;
      inact_q  <= mtlt_pkg::INACTIVITY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mtlt_pkg::CFG_THRESHOLD:  thr_q    <= cfg_data_i;
        mtlt_pkg::CFG_GAP:        gap_q    <= cfg_data_i;
        mtlt_pkg::CFG_DELAY:      delay_q  <= cfg_data_i;
        mtlt_pkg::CFG_LAYER:      target_q <= cfg_data_i[LayerW-1:0];
        mtlt_pkg::CFG_INACTIVITY: inact_q  <= cfg_data_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Next-state logic: one pass per item. A tick advances time, checks the inactivity
  // timeout, folds in motion, then evaluates block release, activation or a stale drop.
  always_comb begin
    logic [TIME_BITS-1:0] tm;
    logic [TIME_BITS-1:0] prev;
    logic [MotionW-1:0]   amount;
    logic [DeltaW:0]      mag;
    logic [MsW-1:0]       rel;
    logic [MsW-1:0]       idle_gap;
    logic                 moved;

    time_d       = time_q;
    pending_d    = pending_q;
    accum_d      = accum_q;
    seen_d       = seen_q;
    seq_start_d  = seq_start_q;
    last_move_d  = last_move_q;
    block_move_d = block_move_q;
    block_d      = block_q;
    active_d     = active_q;
    held_layer_d = held_layer_q;
    held_tmo_d   = held_tmo_q;
    last_act_d   = last_act_q;
    res          = '0;

    tm       = time_q + TIME_BITS'(1);
    prev     = last_move_q;
    amount   = pending_q;
    moved    = 1'b0;
    rel      = (gap_q != '0) ? gap_q : mtlt_pkg::BLOCK_RELEASE_MS;
    idle_gap = (gap_q != '0) ? gap_q : mtlt_pkg::IDLE_DROP_MS;
    // magnitude of the signed delta, up to 2^15
    mag      = move_delta_i[DeltaW-1]
               ? ({1'b1, {DeltaW{1'b0}}} - {1'b0, move_delta_i})
               : {1'b0, move_delta_i};

    case (req_type_i)
      mtlt_pkg::REQ_MOTION: begin
        if (move_delta_i != '0) begin
          last_act_d = time_q;
          seen_d     = 1'b1;
          if (!active_q) begin
            pending_d = mtlt_pkg::sat_add(pending_q, MotionW'(mag));
          end
        end
      end

      mtlt_pkg::REQ_TICK: begin
        time_d = tm;

        // inactivity timeout
        if (active_q && held_tmo_q != '0 && last_act_q != '0 &&
            (tm - last_act_q) >= TIME_BITS'(held_tmo_q)) begin
          active_d            = 1'b0;
          held_tmo_d          = '0;
          last_move_d         = '0;
          accum_d             = '0;
          seq_start_d         = '0;
          pending_d           = '0;
          last_act_d          = '0;
          res.layer_off_pulse = 1'b1;
          res.off_layer       = held_layer_q;
        end

        // fold collected motion into the sequence
        moved  = seen_d;
        seen_d = 1'b0;
        if (moved) begin
          amount      = pending_d;
          prev        = last_move_d;
          pending_d   = '0;
          last_move_d = tm;
          if (block_d) begin
            block_move_d = tm;
            accum_d      = '0;
            seq_start_d  = '0;
          end else if (!active_d) begin
            if (prev == '0 || (gap_q != '0 && (tm - prev) > TIME_BITS'(gap_q))) begin
              accum_d     = '0;
              seq_start_d = tm;
            end else if (seq_start_d == '0) begin
              seq_start_d = tm;
            end
            accum_d = mtlt_pkg::sat_add(accum_d, amount);
          end
        end

        if (block_d) begin
          // release the block once the pointer has stayed idle
          if (!moved && block_move_d != '0 && (tm - block_move_d) >= TIME_BITS'(rel)) begin
            block_d      = 1'b0;
            block_move_d = '0;
            last_move_d  = '0;
            accum_d      = '0;
            seq_start_d  = '0;
            pending_d    = '0;
          end
        end else if (!active_d && seq_start_d != '0) begin
          if (accum_d >= MotionW'(thr_q) &&
              (delay_q == '0 || (tm - seq_start_d) >= TIME_BITS'(delay_q))) begin
            accum_d            = '0;
            seq_start_d        = '0;
            held_tmo_d         = inact_q;
            held_layer_d       = target_q;
            active_d           = 1'b1;
            res.layer_on_pulse = 1'b1;
          end else if (!moved && last_move_d != '0 &&
                       (tm - last_move_d) >= TIME_BITS'(idle_gap)) begin
            // drop a stale sequence
            last_move_d = '0;
            accum_d     = '0;
            seq_start_d = '0;
            pending_d   = '0;
          end
        end
      end

      mtlt_pkg::REQ_FORCE: begin
        block_d             = 1'b1;
        active_d            = 1'b0;
        held_tmo_d          = '0;
        last_move_d         = '0;
        block_move_d        = time_q;
        accum_d             = '0;
        seq_start_d         = '0;
        pending_d           = '0;
        last_act_d          = '0;
        seen_d              = 1'b0;
        res.layer_off_pulse = 1'b1;
        res.off_layer       = force_layer_i;
      end

      default: ;  // unknown request: hold everything
    endcase

    res.layer_active         = active_d;
    res.active_layer         = active_d ? held_layer_d : '0;
    res.reactivation_blocked = block_d;
  end

  // State registers advance only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q       <= '0;
      pending_q    <= '0;
      accum_q      <= '0;
      seen_q       <= 1'b0;
      seq_start_q  <= '0;
      last_move_q  <= '0;
      block_move_q <= '0;
      block_q      <= 1'b0;
      active_q     <= 1'b0;
      held_layer_q <= '0;
      held_tmo_q   <= '0;
      last_act_q   <= '0;
    end else if (in_acc) begin
      time_q       <= time_d;
      pending_q    <= pending_d;
      accum_q      <= accum_d;
      seen_q       <= seen_d;
      seq_start_q  <= seq_start_d;
      last_move_q  <= last_move_d;
      block_move_q <= block_move_d;
      block_q      <= block_d;
      active_q     <= active_d;
      held_layer_q <= held_layer_d;
      held_tmo_q   <= held_tmo_d;
      last_act_q   <= last_act_d;
    end
  end

  // Result buffer control: the skid slot catches an item when the main slot
  // is stalled, and input stops only while the skid slot is full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign layer_active_o         = out_q.layer_active;
  assign active_layer_o         = out_q.active_layer;
  assign layer_on_pulse_o       = out_q.layer_on_pulse;
  assign layer_off_pulse_o      = out_q.layer_off_pulse;
  assign off_layer_o            = out_q.off_layer;
  assign reactivation_blocked_o = out_q.reactivation_blocked;

  // An item never sits in the skid slot with the main slot empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while result slot empty");

  // A force-off block and an active layer exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(active_q && block_q))
    else $error("layer active while reactivation is blocked");

  // An on pulse leaves the layer active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.layer_on_pulse) |=> active_q)
    else $error("on pulse without active layer");

  // A force-off always blocks and deactivates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_type_i == mtlt_pkg::REQ_FORCE) |=> (block_q && !active_q))
    else $error("force-off did not block");

  // A stalled result stays in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

[bench/layer_trigger_checker.sv]
module layer_trigger_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [mtlt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mtlt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [mtlt_pkg::ReqW-1:0]     req_type_i,
  input  logic [mtlt_pkg::DeltaW-1:0]   move_delta_i,
  input  logic [mtlt_pkg::LayerW-1:0]   force_layer_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  mtlt_pkg::result_t             result_i,
  output int                            fail_count_o,
  output int                            pending_count_o
);

  localparam int unsigned TimeW   = mtlt_pkg::TimeBitsDef;
  localparam int unsigned MotionW = mtlt_pkg::MotionW;
  localparam int unsigned MsW     = mtlt_pkg::MsW;
  localparam int unsigned LayerW  = mtlt_pkg::LayerW;
  localparam int unsigned DeltaW  = mtlt_pkg::DeltaW;
  localparam int unsigned ReqW    = mtlt_pkg::ReqW;

  // Register copies
  logic [MsW-1:0]    threshold_q, gap_q, delay_q, timeout_q;
  logic [LayerW-1:0] target_q;

  // Trigger state
  logic [TimeW-1:0]   now_ms, seq_start, last_move, block_move, last_live_move;
  logic [MotionW-1:0] pending_amt, accum_amt;
  logic [LayerW-1:0]  held_layer;
  logic [MsW-1:0]     held_timeout;
  logic               moved_flag, blocked, active;

  mtlt_pkg::result_t expected_layer_q[$];
  mtlt_pkg::result_t want, seen;
  int                failures;

  function automatic logic [TimeW-1:0] elapsed(input logic [TimeW-1:0] stamp);
    return now_ms - stamp;
  endfunction

  function automatic logic [MotionW-1:0] add_clipped(input logic [MotionW-1:0] a,
                                                     input logic [MotionW-1:0] b);
    logic [MotionW:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[MotionW] ? '1 : total[MotionW-1:0];
  endfunction

  function automatic string show(input mtlt_pkg::result_t r);
    return $sformatf("act=%0d layer=%0d on=%0d off=%0d off_layer=%0d blocked=%0d",
                     r.layer_active, r.active_layer, r.layer_on_pulse,
                     r.layer_off_pulse, r.off_layer, r.reactivation_blocked);
  endfunction

  task automatic drop_sequence();
    accum_amt = '0;
    seq_start = '0;
  endtask

  task automatic predict_layer_state(input logic [ReqW-1:0] req,
                                     input logic [DeltaW-1:0] delta,
                                     input logic [LayerW-1:0] flayer,
                                     output mtlt_pkg::result_t r);
    logic [DeltaW:0]    mag;
    logic [MotionW-1:0] amount;
    logic [TimeW-1:0]   prev, window;
    logic               moved, on_p, off_p;
    logic [LayerW-1:0]  off_l;
    on_p  = 1'b0;
    off_p = 1'b0;
    off_l = '0;
    case (req)
      mtlt_pkg::REQ_MOTION: begin
        if (delta != '0) begin
          mag = delta[DeltaW-1] ? ({1'b1, {DeltaW{1'b0}}} - {1'b0, delta}) : {1'b0, delta};
          last_live_move = now_ms;
          moved_flag = 1'b1;
          if (!active) pending_amt = add_clipped(pending_amt, MotionW'(mag));
        end
      end
      mtlt_pkg::REQ_TICK: begin
        now_ms = now_ms + TimeW'(1);
        // inactivity timeout comes first
        if (active && held_timeout != '0 && last_live_move != '0 &&
            elapsed(last_live_move) >= TimeW'(held_timeout)) begin
          active = 1'b0;
          held_timeout = '0;
          last_move = '0;
          drop_sequence();
          pending_amt = '0;
          last_live_move = '0;
          off_p = 1'b1;
          off_l = held_layer;
        end
        moved = moved_flag;
        moved_flag = 1'b0;
        if (moved) begin
          amount = pending_amt;
          prev = last_move;
          pending_amt = '0;
          last_move = now_ms;
          if (blocked) begin
            block_move = now_ms;
            drop_sequence();
          end else if (!active) begin
            if (prev == '0 || (gap_q != '0 && elapsed(prev) > TimeW'(gap_q))) begin
              drop_sequence();
              seq_start = now_ms;
            end else if (seq_start == '0) begin
              seq_start = now_ms;
            end
            accum_amt = add_clipped(accum_amt, amount);
          end
        end
        if (blocked) begin
          window = TimeW'((gap_q != '0) ? gap_q : mtlt_pkg::BLOCK_RELEASE_MS);
          if (!moved && block_move != '0 && elapsed(block_move) >= window) begin
            blocked = 1'b0;
            block_move = '0;
            last_move = '0;
            drop_sequence();
            pending_amt = '0;
          end
        end else if (!active && seq_start != '0) begin
          if (accum_amt >= MotionW'(threshold_q) &&
              (delay_q == '0 || elapsed(seq_start) >= TimeW'(delay_q))) begin
            drop_sequence();
            held_timeout = timeout_q;
            held_layer = target_q;
            active = 1'b1;
            on_p = 1'b1;
          end else begin
            window = TimeW'((gap_q != '0) ? gap_q : mtlt_pkg::IDLE_DROP_MS);
            if (!moved && last_move != '0 && elapsed(last_move) >= window) begin
              last_move = '0;
              drop_sequence();
              pending_amt = '0;
            end
          end
        end
      end
      mtlt_pkg::REQ_FORCE: begin
        blocked = 1'b1;
        active = 1'b0;
        held_timeout = '0;
        last_move = '0;
        block_move = now_ms;
        drop_sequence();
        pending_amt = '0;
        last_live_move = '0;
        moved_flag = 1'b0;
        off_p = 1'b1;
        off_l = flayer;
      end
      default: ;
    endcase
    r.layer_active = active;
    r.active_layer = active ? held_layer : '0;
    r.layer_on_pulse = on_p;
    r.layer_off_pulse = off_p;
    r.off_layer = off_l;
    r.reactivation_blocked = blocked;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q = mtlt_pkg::THRESHOLD_RST;
      gap_q = mtlt_pkg::GAP_RST;
      delay_q = mtlt_pkg::DELAY_RST;
      target_q = mtlt_pkg::LAYER_RST;
      timeout_q = mtlt_pkg::INACTIVITY_RST;
      now_ms = '0;
      seq_start = '0;
      last_move = '0;
      block_move = '0;
      last_live_move = '0;
      pending_amt = '0;
      accum_amt = '0;
      held_layer = '0;
      held_timeout = '0;
      moved_flag = 1'b0;
      blocked = 1'b0;
      active = 1'b0;
      expected_layer_q.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      // retire the result first; it always belongs to an older item
      if (out_valid_i && out_ready_i) begin
        seen = result_i;
        if (expected_layer_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result item with nothing expected: %s", $time, show(seen));
        end else begin
          want = expected_layer_q.pop_front();
          if (seen.layer_active !== want.layer_active ||
              seen.active_layer !== want.active_layer ||
              seen.layer_on_pulse !== want.layer_on_pulse ||
              seen.layer_off_pulse !== want.layer_off_pulse ||
              seen.off_layer !== want.off_layer ||
              seen.reactivation_blocked !== want.reactivation_blocked) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch\n  expected %s\n  actual   %s",
                       $time, show(want), show(seen));
          end
        end
      end
      // an item taken at the same edge as a register write still sees the old value
      if (in_valid_i && in_ready_i) begin
        predict_layer_state(req_type_i, move_delta_i, force_layer_i, want);
        expected_layer_q.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mtlt_pkg::CFG_THRESHOLD:  threshold_q = cfg_data_i;
          mtlt_pkg::CFG_GAP:        gap_q = cfg_data_i;
          mtlt_pkg::CFG_DELAY:      delay_q = cfg_data_i;
          mtlt_pkg::CFG_LAYER:      target_q = cfg_data_i[LayerW-1:0];
          mtlt_pkg::CFG_INACTIVITY: timeout_q = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= failures;
      pending_count_o <= expected_layer_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
module tb_top;

  localparam int unsigned ReqW     = mtlt_pkg::ReqW;
  localparam int unsigned CfgIdxW  = mtlt_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = mtlt_pkg::CfgDataW;
  localparam int unsigned DeltaW   = mtlt_pkg::DeltaW;
  localparam int unsigned LayerW   = mtlt_pkg::LayerW;
  localparam int unsigned MsW      = mtlt_pkg::MsW;

  // Request code with no meaning; the block must leave its state alone.
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ReqW-1:0]     req_type = '0;
  logic [DeltaW-1:0]   move_delta = '0;
  logic [LayerW-1:0]   force_layer = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                layer_active, on_pulse, off_pulse, blocked;
  logic [LayerW-1:0]   active_layer, off_layer;
  int                  fail_count, pending_count;

  // Count of accepted input items; paces the quiet stretch and the long stall.
  int items_sent = 0;

  motion_threshold_layer_trigger dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .req_type_i             (req_type),
    .move_delta_i           (move_delta),
    .force_layer_i          (force_layer),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .layer_active_o         (layer_active),
    .active_layer_o         (active_layer),
    .layer_on_pulse_o       (on_pulse),
    .layer_off_pulse_o      (off_pulse),
    .off_layer_o            (off_layer),
    .reactivation_blocked_o (blocked)
  );

  layer_trigger_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .req_type_i      (req_type),
    .move_delta_i    (move_delta),
    .force_layer_i   (force_layer),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .result_i        ({layer_active, active_layer, on_pulse, off_pulse, off_layer, blocked}),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the handshakes lock up.
  initial begin
    #(100_000 * 20);
    $display("*** FAILED ***");
    $finish;
  end

  // Both sides run without any idling inside this window of items.
  function automatic bit calm_stretch();
    return items_sent >= 400 && items_sent < 560;
  endfunction

  // Mostly small motion, with zero and both extremes mixed in.
  function automatic logic [DeltaW-1:0] pick_delta();
    int unsigned       roll;
    logic [DeltaW-1:0] mag;
    roll = $urandom_range(99);
    mag  = DeltaW'($urandom_range(40, 1));
    if (roll < 6) return '0;
    if (roll < 11) return 16'h8000;
    if (roll < 16) return 16'h7fff;
    if (roll < 70) return roll[0] ? -mag : mag;
    return DeltaW'($urandom);
  endfunction

  // Write one register; lower valid at the accepting edge, so every call
  // starts on a fresh edge.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_setting(input logic [MsW-1:0] thr, input logic [MsW-1:0] gap,
                                 input logic [MsW-1:0] delay, input logic [LayerW-1:0] layer,
                                 input logic [MsW-1:0] tmo);
    write_register(mtlt_pkg::CFG_THRESHOLD, thr);
    write_register(mtlt_pkg::CFG_GAP, gap);
    write_register(mtlt_pkg::CFG_DELAY, delay);
    write_register(mtlt_pkg::CFG_LAYER, CfgDataW'(layer));
    write_register(mtlt_pkg::CFG_INACTIVITY, tmo);
  endtask

  // Offer one item and return at the edge that takes it; valid stays up so
  // that the next item can follow back to back.
  task automatic offer_request(input logic [ReqW-1:0] req, input logic [DeltaW-1:0] delta,
                               input logic [LayerW-1:0] layer);
    if (!calm_stretch() && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    move_delta  <= delta;
    force_layer <= layer;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_tick();
    offer_request(mtlt_pkg::REQ_TICK, DeltaW'($urandom), LayerW'($urandom));
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Receiver: random short stalls, plus one long hold-off that backs the
  // block up while the sender keeps offering.
  initial begin
    int held;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= 250) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (held = 0; held < 120; held++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm_stretch() && $urandom_range(99) < 6) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned roll;
    int          made;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: short windows so timeout, delay and release all show up.
    program_setting(16'd100, 16'd3, 16'd2, 5'd31, 16'd4);
    offer_request(mtlt_pkg::REQ_MOTION, 16'd5, 5'd0);       // motion stamped at time zero
    offer_request(mtlt_pkg::REQ_MOTION, 16'd0, 5'd31);      // zero motion, ignored
    send_tick();                                            // sequence starts
    offer_request(mtlt_pkg::REQ_MOTION, 16'h8000, 5'd0);    // most negative delta
    send_tick();                                            // enough motion, delay not met
    send_tick();                                            // delay met, layer turns on
    offer_request(mtlt_pkg::REQ_MOTION, 16'h7fff, 5'd0);    // motion while on
    repeat (5) send_tick();                                 // inactivity turns it off
    offer_request(REQ_UNUSED, 16'hffff, 5'd31);             // unknown request
    offer_request(mtlt_pkg::REQ_MOTION, 16'hffff, 5'd0);
    offer_request(mtlt_pkg::REQ_FORCE, 16'd0, 5'd21);       // force-off blocks reactivation
    offer_request(mtlt_pkg::REQ_MOTION, 16'd1, 5'd10);
    repeat (5) send_tick();                                 // motion, then idle until release
    offer_request(mtlt_pkg::REQ_FORCE, 16'hffff, 5'd0);     // force-off while nothing is on
    drain();

    // Random part: extremes first, then short random windows.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_setting(16'd0, 16'd0, 16'd0, 5'd0, 16'd0);
        1: program_setting(16'hffff, 16'hffff, 16'hffff, 5'd31, 16'hffff);
        default: program_setting(MsW'($urandom_range(300)), MsW'($urandom_range(12)),
                                 MsW'($urandom_range(6)), LayerW'($urandom),
                                 MsW'($urandom_range(10)));
      endcase
      made = 0;
      while (made < 150) begin
        roll = $urandom_range(99);
        if (roll < 50) begin
          // burst: a few deltas per tick, like a pointer in motion
          repeat ($urandom_range(8, 2)) begin
            repeat ($urandom_range(3, 1)) begin
              offer_request(mtlt_pkg::REQ_MOTION, pick_delta(), LayerW'($urandom));
              made++;
            end
            send_tick();
            made++;
          end
        end else if (roll < 85) begin
          // idle run: long enough to cross gaps and timeouts
          repeat ($urandom_range(20, 1)) begin
            send_tick();
            made++;
          end
        end else if (roll < 92) begin
          offer_request(mtlt_pkg::REQ_FORCE, DeltaW'($urandom), LayerW'($urandom));
          made++;
        end else if (roll[0]) begin
          offer_request(REQ_UNUSED, DeltaW'($urandom), LayerW'($urandom));
        end else begin
          offer_request(mtlt_pkg::REQ_MOTION, '0, LayerW'($urandom));
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mtlt_pkg.sv
rtl/motion_threshold_layer_trigger.sv
bench/layer_trigger_checker.sv
bench/tb_top.sv
